@@ hw/rtl/tgt_pkg.sv @@
// ----------------------------------------------------------------------------
// tgt_pkg
// Shared widths, codes and the quarter-wave sine table of the torus grid
// tessellator.
// ----------------------------------------------------------------------------
package tgt_pkg;

   // field and datapath widths
   localparam int CNT_W     = 11;
   localparam int IDX_W     = 10;
   localparam int RAD_W     = 16;
   localparam int ANG_W     = 16;
   localparam int VTX_W     = 20;
   localparam int POS_W     = 18;

   // reciprocal of a count: floor(2^REC_SHIFT / count)
   localparam int REC_SHIFT = 26;
   localparam int REC_W     = REC_SHIFT + 1;
   localparam int STEP_W    = 5;

   // modulo 23 by reciprocal multiplication, exact below 2^23
   localparam int                MOD23_DIV   = 23;
   localparam int                MOD23_SHIFT = 26;
   localparam logic [21:0]       MOD23_MUL   = 22'd2917777;

   // one in Q1.14 and the rounding half for Q1.14 products
   localparam int Q14_ONE  = 16384;
   localparam int Q14_HALF = 8192;
   localparam int Q14_FRAC = 14;

   // shape codes
   typedef enum logic [2:0] {
      MODE_TORUS      = 3'd0,
      MODE_HALF       = 3'd1,
      MODE_UNDERCUT   = 3'd2,
      MODE_SPIKES     = 3'd3,
      MODE_COMPONENTS = 3'd4,
      MODE_SELF_X     = 3'd5
   } shape_type;

   // register indexes of the configuration port
   typedef enum logic [2:0] {
      REG_RING_RADIUS = 3'd0,
      REG_TUBE_RADIUS = 3'd1,
      REG_TUBE_OUTER  = 3'd2,
      REG_POINTS      = 3'd3,
      REG_RINGS       = 3'd4,
      REG_SHAPE       = 3'd5
   } reg_type;

   // quarter-wave sine, step 1/128 turn, Q1.14
   localparam logic [14:0] SIN_TAB [33] = '{
      15'd0,     15'd804,   15'd1606,  15'd2404,  15'd3196,  15'd3981,
      15'd4756,  15'd5520,  15'd6270,  15'd7005,  15'd7723,  15'd8423,
      15'd9102,  15'd9760,  15'd10394, 15'd11003, 15'd11585, 15'd12140,
      15'd12665, 15'd13160, 15'd13623, 15'd14053, 15'd14449, 15'd14811,
      15'd15137, 15'd15426, 15'd15679, 15'd15893, 15'd16069, 15'd16207,
      15'd16305, 15'd16364, 15'd16384
   };

   // table look-up result ahead of the interpolation multiply
   typedef struct packed {
      logic [14:0] base;
      logic [9:0]  step;
      logic [8:0]  frac;
      logic        neg;
      logic        full;
   } trig_prep_type;

   // quadrant fold and table look-up for one angle
   function automatic trig_prep_type sin_prep(input logic [ANG_W-1:0] ang);
      trig_prep_type res;
      logic [14:0]   p;
      logic [5:0]    k;
      logic [5:0]    k_lo;
      logic [5:0]    k_hi;
      p = {1'b0, ang[13:0]};
      if (ang[14]) begin
         p = 15'(Q14_ONE) - p;
      end
      k        = p[14:9];
      res.full = p[14];
      k_lo     = res.full ? 6'd31 : k;
      k_hi     = k_lo + 6'd1;
      res.base = SIN_TAB[k_lo];
      res.step = 10'(SIN_TAB[k_hi] - SIN_TAB[k_lo]);
      res.frac = p[8:0];
      res.neg  = ang[15];
      return res;
   endfunction

endpackage

@@ hw/rtl/torus_grid_tessellator.sv @@
// ----------------------------------------------------------------------------
// torus_grid_tessellator
// Vertex position and triangle indices for one grid point of a torus mesh.
// ----------------------------------------------------------------------------
// Takes one grid point (ring i, point j) per cycle while req_tready is
// high and returns its Q10.8 vertex position and up to two triangles of
// wrapped vertex indices through a nine-stage pipeline that stalls as a
// whole only when the result register is held. Angles come from a
// reciprocal multiply with one correction step; the reciprocals of
// ring_count and points_per_ring are each rebuilt by their own bit-serial
// divider after a write to that register, during which no grid point is
// taken (configuration transfers are always taken). rsp_tuser[2] flags an
// index at or beyond its count; the rest of that result is zero.
// ----------------------------------------------------------------------------
module torus_grid_tessellator #(
   parameter int MAX_RES = 1024
) (
   input  logic          clock,
   input  logic          reset,
   // grid point: ring_index, point_index
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [23:0]   req_tdata,
   // pos_x, pos_y, pos_z, first_tri_v0..v2, second_tri_v0..v2
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [175:0]  rsp_tdata,
   // first_tri_valid, second_tri_valid, index_error
   output logic [2:0]    rsp_tuser,
   // register write
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [2:0]    csr_index,
   input  logic [15:0]   csr_data
);

   localparam int CNT_W    = tgt_pkg::CNT_W;
   localparam int IDX_W    = tgt_pkg::IDX_W;
   localparam int REC_W    = tgt_pkg::REC_W;
   localparam int VTX_W    = tgt_pkg::VTX_W;
   localparam int POS_W    = tgt_pkg::POS_W;
   localparam int RST_CNT  = (MAX_RES < 16) ? MAX_RES : 16;
   localparam logic [REC_W-1:0] RST_REC = REC_W'((1 << tgt_pkg::REC_SHIFT) / RST_CNT);
   localparam int NSTG     = 9;
   localparam int LAST     = NSTG - 1;

   // trig slots
   localparam int TRIG_SA = 0;
   localparam int TRIG_CA = 1;
   localparam int TRIG_SB = 2;
   localparam int TRIG_CB = 3;
   localparam int TRIG_SZ = 4;

   typedef struct packed {
      logic                         vld;
      logic                         err;
      tgt_pkg::shape_type           mode;
      logic [IDX_W-1:0]             i;
      logic [IDX_W-1:0]             j;
      logic [CNT_W-1:0]             iu;
      logic [CNT_W-1:0]             id;
      logic [CNT_W-1:0]             jr;
      logic [CNT_W-1:0]             jl;
      logic [CNT_W-1:0]             rc;
      logic [CNT_W-1:0]             pc;
      logic [IDX_W+REC_W-1:0]       pa;
      logic [IDX_W+REC_W-1:0]       pb;
      logic [21:0]                  sx;
      logic [17:0]                  sq;
      logic [15:0]                  qa;
      logic [15:0]                  qb;
      logic [26:0]                  qra;
      logic [26:0]                  qrb;
      logic [VTX_W-1:0]             ip;
      logic [VTX_W-1:0]             iup;
      logic [VTX_W-1:0]             idp;
      logic                         hit;
      logic                         t1;
      logic                         t2;
      logic [5:0][VTX_W-1:0]        v;
      logic [15:0]                  ang_a;
      logic [15:0]                  ang_b;
      logic [15:0]                  zang;
      tgt_pkg::trig_prep_type [4:0] tp;
      logic [4:0][18:0]             df;
      logic [4:0][15:0]             sv;
      logic [15:0]                  r;
      logic signed [32:0]           m;
      logic signed [32:0]           zp;
      logic signed [17:0]           rr;
      logic signed [17:0]           z;
      logic signed [33:0]           px;
      logic signed [33:0]           py;
      logic [POS_W-1:0]             ox;
      logic [POS_W-1:0]             oy;
   } pl_type;

   // configuration registers
   logic [15:0]       ring_radius_ff;
   logic [15:0]       tube_radius_ff;
   logic [15:0]       tube_outer_ff;
   logic [CNT_W-1:0]  points_ff;
   logic [CNT_W-1:0]  rings_ff;
   logic [2:0]        mode_ff;

   logic              cfg_wr;
   logic              start_r;
   logic              start_p;
   logic [CNT_W-1:0]  new_cnt;
   logic              busy_r;
   logic              busy_p;
   logic [REC_W-1:0]  rec_r;
   logic [REC_W-1:0]  rec_p;

   logic [CNT_W-1:0]   rc_cur;
   logic [CNT_W-1:0]   pc_cur;
   tgt_pkg::shape_type mode_cur;

   logic    en;
   pl_type  st_ff [NSTG];
   pl_type  st_in [NSTG];

   function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] c);
      return (int'(c) > MAX_RES) ? CNT_W'(MAX_RES) : c;
   endfunction

   function automatic logic [POS_W-1:0] sat18(input logic signed [19:0] v);
      if (v > 20'sd131071) begin
         return POS_W'(131071);
      end else if (v < -20'sd131072) begin
         return POS_W'(-131072);
      end
      return v[POS_W-1:0];
   endfunction

   function automatic logic [15:0] sin_value(input tgt_pkg::trig_prep_type tp,
                                             input logic [18:0] df);
      logic [19:0] rnd;
      logic [14:0] mag;
      rnd = {1'b0, df} + 20'd256;
      mag = tp.full ? 15'(tgt_pkg::Q14_ONE) : (tp.base + 15'(rnd[19:9]));
      return tp.neg ? (16'd0 - {1'b0, mag}) : {1'b0, mag};
   endfunction

   // register writes
   assign cfg_wr    = csr_valid && csr_ready;
   assign csr_ready = 1'b1;
   assign new_cnt   = clamp_cnt(csr_data[CNT_W-1:0]);
   assign start_r   = cfg_wr && (csr_index == tgt_pkg::REG_RINGS);
   assign start_p   = cfg_wr && (csr_index == tgt_pkg::REG_POINTS);

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_radius_ff <= 16'd512;
         tube_radius_ff <= 16'd256;
         tube_outer_ff  <= 16'd384;
         points_ff      <= CNT_W'(16);
         rings_ff       <= CNT_W'(16);
         mode_ff        <= tgt_pkg::MODE_TORUS;
      end else if (cfg_wr) begin
         case (csr_index)
            tgt_pkg::REG_RING_RADIUS: ring_radius_ff <= csr_data;
            tgt_pkg::REG_TUBE_RADIUS: tube_radius_ff <= csr_data;
            tgt_pkg::REG_TUBE_OUTER:  tube_outer_ff  <= csr_data;
            tgt_pkg::REG_POINTS:      points_ff      <= csr_data[CNT_W-1:0];
            tgt_pkg::REG_RINGS:       rings_ff       <= csr_data[CNT_W-1:0];
            tgt_pkg::REG_SHAPE:       mode_ff        <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // reciprocals of the clamped counts
   tgt_recip #(.RESET_RECIP(RST_REC)) u_recip_rings (
      .clock   (clock),
      .reset   (reset),
      .start   (start_r),
      .divisor (new_cnt),
      .busy    (busy_r),
      .recip   (rec_r)
   );

   tgt_recip #(.RESET_RECIP(RST_REC)) u_recip_points (
      .clock   (clock),
      .reset   (reset),
      .start   (start_p),
      .divisor (new_cnt),
      .busy    (busy_p),
      .recip   (rec_p)
   );

   assign rc_cur   = clamp_cnt(rings_ff);
   assign pc_cur   = clamp_cnt(points_ff);
   assign mode_cur = (mode_ff inside {[3'd0:3'd5]}) ? tgt_pkg::shape_type'(mode_ff)
                                                    : tgt_pkg::MODE_TORUS;

   // whole pipeline moves unless the result register is held
   assign en         = !st_ff[LAST].vld || rsp_tready;
   assign req_tready = en && !busy_r && !busy_p && !csr_valid;

   // stage 0: capture, neighbours, reciprocal products
   always_comb begin
      logic [CNT_W-1:0] i1;
      logic [CNT_W-1:0] j1;
      st_in[0]      = '0;
      st_in[0].vld  = req_tvalid && req_tready;
      st_in[0].i    = req_tdata[IDX_W-1:0];
      st_in[0].j    = req_tdata[2*IDX_W-1:IDX_W];
      st_in[0].rc   = rc_cur;
      st_in[0].pc   = pc_cur;
      st_in[0].mode = mode_cur;
      st_in[0].err  = ({1'b0, st_in[0].i} >= rc_cur) || ({1'b0, st_in[0].j} >= pc_cur);
      i1 = {1'b0, st_in[0].i} + CNT_W'(1);
      j1 = {1'b0, st_in[0].j} + CNT_W'(1);
      st_in[0].iu = (i1 == rc_cur) ? '0 : i1;
      st_in[0].jr = (j1 == pc_cur) ? '0 : j1;
      st_in[0].id = (st_in[0].i == '0) ? (rc_cur - CNT_W'(1)) : ({1'b0, st_in[0].i} - CNT_W'(1));
      st_in[0].jl = (st_in[0].j == '0) ? (pc_cur - CNT_W'(1)) : ({1'b0, st_in[0].j} - CNT_W'(1));
      st_in[0].pa = st_in[0].i * rec_r;
      st_in[0].pb = st_in[0].j * rec_p;
      st_in[0].sx = 22'(st_in[0].i) * 22'(rc_cur) + 22'(st_in[0].j);
   end

   // stage 1: quotient estimates, row bases, mod 23 quotient
   always_comb begin
      logic [43:0] sprod;
      st_in[1]     = st_ff[0];
      st_in[1].qa  = st_ff[0].pa[25:10];
      st_in[1].qb  = st_ff[0].pb[25:10];
      st_in[1].qra = st_in[1].qa * st_ff[0].rc;
      st_in[1].qrb = st_in[1].qb * st_ff[0].pc;
      sprod        = st_ff[0].sx * tgt_pkg::MOD23_MUL;
      st_in[1].sq  = sprod[tgt_pkg::MOD23_SHIFT +: 18];
      st_in[1].ip  = VTX_W'(st_ff[0].i) * VTX_W'(st_ff[0].pc);
      st_in[1].iup = VTX_W'(st_ff[0].iu) * VTX_W'(st_ff[0].pc);
      st_in[1].idp = VTX_W'(st_ff[0].id) * VTX_W'(st_ff[0].pc);
   end

   // stage 2: quotient correction, angles, spike test, triangles
   always_comb begin
      logic [26:0]      rem_a;
      logic [26:0]      rem_b;
      logic [15:0]      qa_f;
      logic [15:0]      qb_f;
      logic             last_ring;
      logic             split;
      logic [VTX_W-1:0] jx;
      logic [VTX_W-1:0] jrx;
      logic [VTX_W-1:0] jlx;
      st_in[2] = st_ff[1];
      rem_a = 27'({st_ff[1].i, 16'h0000}) - st_ff[1].qra;
      rem_b = 27'({st_ff[1].j, 16'h0000}) - st_ff[1].qrb;
      qa_f  = (rem_a >= 27'(st_ff[1].rc)) ? st_ff[1].qa + 16'd1 : st_ff[1].qa;
      qb_f  = (rem_b >= 27'(st_ff[1].pc)) ? st_ff[1].qb + 16'd1 : st_ff[1].qb;
      st_in[2].ang_a = (st_ff[1].mode == tgt_pkg::MODE_HALF) ? ({1'b0, qa_f[15:1]} + 16'd16384)
                                                             : qa_f;
      st_in[2].ang_b = qb_f;
      st_in[2].zang  = (st_ff[1].mode == tgt_pkg::MODE_SELF_X) ? {st_in[2].ang_a[14:0], 1'b0}
                                                               : st_in[2].ang_a;
      st_in[2].hit = (st_ff[1].sx - 22'(st_ff[1].sq * 22'(tgt_pkg::MOD23_DIV))) == '0;

      // triangle presence per shape
      last_ring = (st_ff[1].iu == '0);
      split     = (st_ff[1].mode != tgt_pkg::MODE_TORUS);
      st_in[2].t1 = !(((st_ff[1].mode == tgt_pkg::MODE_HALF) && last_ring) ||
                      ((st_ff[1].mode == tgt_pkg::MODE_COMPONENTS) &&
                       (st_ff[1].i[0] || last_ring)));
      st_in[2].t2 = st_in[2].t1;

      // wrapped vertex indices
      jx  = VTX_W'(st_ff[1].j);
      jrx = VTX_W'(st_ff[1].jr);
      jlx = VTX_W'(st_ff[1].jl);
      st_in[2].v[0] = st_ff[1].ip + jx;
      st_in[2].v[1] = st_ff[1].iup + jx;
      st_in[2].v[2] = st_ff[1].ip + jrx;
      st_in[2].v[3] = split ? (st_ff[1].ip + jrx) : (st_ff[1].ip + jx);
      st_in[2].v[4] = split ? (st_ff[1].iup + jx) : (st_ff[1].idp + jx);
      st_in[2].v[5] = split ? (st_ff[1].iup + jrx) : (st_ff[1].ip + jlx);
   end

   // stage 3: table look-up and interpolation products
   always_comb begin
      logic [4:0][15:0] ang;
      st_in[3] = st_ff[2];
      ang[TRIG_SA] = st_ff[2].ang_a;
      ang[TRIG_CA] = st_ff[2].ang_a + 16'd16384;
      ang[TRIG_SB] = st_ff[2].ang_b;
      ang[TRIG_CB] = st_ff[2].ang_b + 16'd16384;
      ang[TRIG_SZ] = st_ff[2].zang;
      for (int k = 0; k < 5; k++) begin
         st_in[3].tp[k] = tgt_pkg::sin_prep(ang[k]);
         st_in[3].df[k] = st_in[3].tp[k].step * st_in[3].tp[k].frac;
      end
   end

   // stage 4: sine and cosine values
   always_comb begin
      st_in[4] = st_ff[3];
      for (int k = 0; k < 5; k++) begin
         st_in[4].sv[k] = sin_value(st_ff[3].tp[k], st_ff[3].df[k]);
      end
   end

   // stage 5: tube radius choice and radius products
   always_comb begin
      logic outer;
      st_in[5] = st_ff[4];
      outer = ((st_ff[4].mode == tgt_pkg::MODE_UNDERCUT) &&
               ($signed(st_ff[4].sv[TRIG_SA]) > 16'sd0)) ||
              ((st_ff[4].mode == tgt_pkg::MODE_SPIKES) && st_ff[4].hit);
      st_in[5].r  = outer ? tube_outer_ff : tube_radius_ff;
      st_in[5].m  = $signed({1'b0, st_in[5].r}) * $signed(st_ff[4].sv[TRIG_CA]);
      st_in[5].zp = $signed({1'b0, st_in[5].r}) * $signed(st_ff[4].sv[TRIG_SZ]);
   end

   // stage 6: rounding, distance from axis, height
   always_comb begin
      logic signed [32:0] mr;
      logic signed [32:0] zr;
      st_in[6] = st_ff[5];
      mr = (st_ff[5].m + 33'(tgt_pkg::Q14_HALF)) >>> tgt_pkg::Q14_FRAC;
      zr = (st_ff[5].zp + 33'(tgt_pkg::Q14_HALF)) >>> tgt_pkg::Q14_FRAC;
      st_in[6].rr = $signed({2'b00, ring_radius_ff}) - $signed(mr[17:0]);
      st_in[6].z  = ((st_ff[5].mode == tgt_pkg::MODE_UNDERCUT) &&
                     ($signed(st_ff[5].sv[TRIG_SA]) <= 16'sd0)) ? -$signed(zr[17:0])
                                                                : $signed(zr[17:0]);
   end

   // stage 7: planar products
   always_comb begin
      st_in[7]    = st_ff[6];
      st_in[7].px = st_ff[6].rr * $signed(st_ff[6].sv[TRIG_CB]);
      st_in[7].py = st_ff[6].rr * $signed(st_ff[6].sv[TRIG_SB]);
   end

   // stage 8: rounding and saturation into the result register
   always_comb begin
      logic signed [33:0] xr;
      logic signed [33:0] yr;
      st_in[8] = st_ff[7];
      xr = (st_ff[7].px + 34'(tgt_pkg::Q14_HALF)) >>> tgt_pkg::Q14_FRAC;
      yr = (st_ff[7].py + 34'(tgt_pkg::Q14_HALF)) >>> tgt_pkg::Q14_FRAC;
      st_in[8].ox = sat18($signed(xr[19:0]));
      st_in[8].oy = sat18($signed(yr[19:0]));
   end

   // pipeline registers, valid bits cleared on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NSTG; k++) begin
            st_ff[k].vld <= 1'b0;
         end
      end else if (en) begin
         for (int k = 0; k < NSTG; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   // result transfer
   always_comb begin
      logic             e;
      logic             f1;
      logic             f2;
      logic [VTX_W-1:0] z20;
      e   = st_ff[LAST].err;
      f1  = st_ff[LAST].t1 && !e;
      f2  = st_ff[LAST].t2 && !e;
      z20 = '0;
      rsp_tvalid = st_ff[LAST].vld;
      rsp_tdata  = e ? '0 : {2'b00,
                             f2 ? st_ff[LAST].v[5] : z20,
                             f2 ? st_ff[LAST].v[4] : z20,
                             f2 ? st_ff[LAST].v[3] : z20,
                             f1 ? st_ff[LAST].v[2] : z20,
                             f1 ? st_ff[LAST].v[1] : z20,
                             f1 ? st_ff[LAST].v[0] : z20,
                             st_ff[LAST].z,
                             st_ff[LAST].oy,
                             st_ff[LAST].ox};
      rsp_tuser  = {e, f2, f1};
   end

   // no grid point is taken while a reciprocal is being rebuilt
   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      (busy_r || busy_p) |-> !req_tready)
      else $error("grid point taken during reciprocal rebuild");

   // a ring count write starts the ring divider
   a_count_start: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && (csr_index == tgt_pkg::REG_RINGS)) |=> busy_r)
      else $error("ring count write did not start the divider");

   // an index error carries nothing else
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[2]) |-> (rsp_tuser[1:0] == 2'b00 && rsp_tdata == '0))
      else $error("index error with payload");

   // both triangles of a cell come and go together
   a_tri_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[0] == rsp_tuser[1]))
      else $error("triangle valid bits differ");

endmodule

@@ hw/rtl/tgt_recip.sv @@
// ----------------------------------------------------------------------------
// tgt_recip
// Restoring divider that forms floor(2^26 / count), one quotient bit a cycle.
// ----------------------------------------------------------------------------
module tgt_recip #(
   parameter logic [26:0] RESET_RECIP = 27'd4194304
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tgt_pkg::CNT_W-1:0]   divisor,
   output logic                        busy,
   output logic [tgt_pkg::REC_W-1:0]   recip
);

   logic                        busy_ff;
   logic [tgt_pkg::STEP_W-1:0]  step_ff;
   logic [tgt_pkg::CNT_W:0]     rem_ff;
   logic [tgt_pkg::CNT_W:0]     rem_in;
   logic [tgt_pkg::CNT_W-1:0]   div_ff;
   logic [tgt_pkg::REC_W-1:0]   quo_ff;
   logic [tgt_pkg::REC_W-1:0]   quo_in;
   logic [tgt_pkg::CNT_W:0]     shifted;
   logic                        fits;

   // one restoring step: the numerator has its only set bit at the top
   always_comb begin
      shifted = {rem_ff[tgt_pkg::CNT_W-1:0], (step_ff == tgt_pkg::STEP_W'(tgt_pkg::REC_SHIFT))};
      fits    = shifted >= {1'b0, div_ff};
      rem_in  = fits ? (shifted - {1'b0, div_ff}) : shifted;
      quo_in  = {quo_ff[tgt_pkg::REC_W-2:0], fits};
   end

   // sequencer and quotient register
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         quo_ff  <= RESET_RECIP;
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= tgt_pkg::STEP_W'(tgt_pkg::REC_SHIFT);
         rem_ff  <= '0;
         div_ff  <= divisor;
         quo_ff  <= '0;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         step_ff <= step_ff - tgt_pkg::STEP_W'(1);
         if (step_ff == '0) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy  = busy_ff;
   assign recip = quo_ff;

endmodule
